// File: src/x86_shift_rotate_unit_macros.svh
// assertion macros for the shift and rotate unit
`ifndef X86_SHIFT_ROTATE_UNIT_MACROS_SVH
`define X86_SHIFT_ROTATE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, consequent may carry a fixed delay
`define SRU_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sru assertion failed");
// next-cycle implication
`define SRU_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sru assertion failed");
`else
`define SRU_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define SRU_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// File: src/sru_pkg.sv
// shared types, constants and helpers of the shift and rotate unit
package sru_pkg;

   localparam int MAX_WIDTH = 64;
   localparam int CNT_WIDTH = 6;
   localparam int AMT_WIDTH = 7;

   localparam logic [CNT_WIDTH-1:0] CNT_MASK_WIDE   = 6'h3F;
   localparam logic [CNT_WIDTH-1:0] CNT_MASK_NARROW = 6'h1F;

   typedef enum logic [3:0] {
      OP_SHL  = 4'd0,
      OP_SHR  = 4'd1,
      OP_SAR  = 4'd2,
      OP_ROL  = 4'd3,
      OP_ROR  = 4'd4,
      OP_SHLD = 4'd5,
      OP_SHRD = 4'd6,
      OP_RCL  = 4'd7,
      OP_RCR  = 4'd8
   } op_type;

   typedef enum logic [1:0] {
      SIZE_BYTE  = 2'd0,
      SIZE_WORD  = 2'd1,
      SIZE_DWORD = 2'd2,
      SIZE_QWORD = 2'd3
   } size_type;

   typedef logic [MAX_WIDTH-1:0] word_type;
   typedef logic [AMT_WIDTH-1:0] amt_type;

   // shifter result handed to the flag logic
   typedef struct packed {
      word_type               result;
      logic                   carry;
      logic                   overflow;
      logic                   active;
      logic                   arith;
      logic [CNT_WIDTH-1:0]   msb;
   } shift_out_type;

   // bit of x at idx, zero beyond the word
   function automatic logic bit_at(input word_type x, input amt_type idx);
      logic b;
      if (idx[AMT_WIDTH-1]) begin
         b = 1'b0;
      end else begin
         b = x[idx[CNT_WIDTH-1:0]];
      end
      return b;
   endfunction

   // count modulo 9 for byte rotate through carry, count below 32
   function automatic logic [4:0] mod9(input logic [4:0] c);
      logic [4:0] m;
      if (c >= 5'd27) begin
         m = c - 5'd27;
      end else if (c >= 5'd18) begin
         m = c - 5'd18;
      end else if (c >= 5'd9) begin
         m = c - 5'd9;
      end else begin
         m = c;
      end
      return m;
   endfunction

endpackage

// File: src/sru_shifter.sv
// barrel shifter: result value, carry and overflow for every operation
module sru_shifter (
   input  logic [3:0]              operation,
   input  logic [1:0]              operand_size,
   input  sru_pkg::word_type       dest_value,
   input  sru_pkg::word_type       fill_value,
   input  logic [7:0]              shift_count,
   input  logic                    carry_in,
   input  logic                    overflow_in,
   output sru_pkg::shift_out_type  shift_out
);

   sru_pkg::word_type                 mask;
   sru_pkg::word_type                 d;
   sru_pkg::word_type                 f;
   sru_pkg::word_type                 r;
   sru_pkg::amt_type                  bits;
   sru_pkg::amt_type                  cnt;
   sru_pkg::amt_type                  cnt_m1;
   sru_pkg::amt_type                  bits_m_cnt;
   sru_pkg::amt_type                  rot_n;
   sru_pkg::amt_type                  rc_n;
   logic [sru_pkg::CNT_WIDTH-1:0]     msb;
   logic [sru_pkg::CNT_WIDTH-1:0]     cnt_raw;
   logic                              sgn;
   logic                              cf;
   logic                              of;
   logic                              active;
   logic                              arith;
   logic                              cnt_one;

   always_comb begin
      case (operand_size)
         sru_pkg::SIZE_BYTE:  mask = 64'h0000_0000_0000_00FF;
         sru_pkg::SIZE_WORD:  mask = 64'h0000_0000_0000_FFFF;
         sru_pkg::SIZE_DWORD: mask = 64'h0000_0000_FFFF_FFFF;
         default:             mask = 64'hFFFF_FFFF_FFFF_FFFF;
      endcase
   end

   assign bits = sru_pkg::amt_type'(7'd8 << operand_size);
   assign msb  = sru_pkg::CNT_WIDTH'(bits - 7'd1);
   assign d    = dest_value & mask;
   assign f    = fill_value & mask;

   assign cnt_raw = (operand_size == sru_pkg::SIZE_QWORD)
                    ? (shift_count[5:0] & sru_pkg::CNT_MASK_WIDE)
                    : (shift_count[5:0] & sru_pkg::CNT_MASK_NARROW);
   assign cnt        = {1'b0, cnt_raw};
   assign cnt_m1     = cnt - 7'd1;
   assign bits_m_cnt = bits - cnt;
   assign cnt_one    = (cnt == 7'd1);
   assign sgn        = d[msb];

   // rotate amount: byte and word fold the count into the width
   assign rot_n = cnt & {1'b0, msb};

   // rotate through carry amount: byte and word fold modulo width plus one
   always_comb begin
      case (operand_size)
         sru_pkg::SIZE_BYTE: rc_n = {2'b00, sru_pkg::mod9(cnt_raw[4:0])};
         sru_pkg::SIZE_WORD: rc_n = (cnt_raw[4:0] >= 5'd17)
                                    ? {2'b00, cnt_raw[4:0] - 5'd17}
                                    : {2'b00, cnt_raw[4:0]};
         default:            rc_n = cnt;
      endcase
   end

   always_comb begin
      r      = d;
      cf     = carry_in;
      of     = overflow_in;
      arith  = 1'b0;
      active = (cnt != 7'd0) && (operation <= 4'(sru_pkg::OP_RCR));
      if (active) begin
         case (operation)
            sru_pkg::OP_SHL: begin
               r  = (d << cnt) & mask;
               cf = (cnt <= bits) ? sru_pkg::bit_at(d, bits_m_cnt) : 1'b0;
               if (cnt_one) of = r[msb] ^ cf;
               arith = 1'b1;
            end
            sru_pkg::OP_SHR: begin
               r  = d >> cnt;
               cf = sru_pkg::bit_at(d, cnt_m1);
               if (cnt_one) of = d[msb];
               arith = 1'b1;
            end
            sru_pkg::OP_SAR: begin
               if (cnt >= bits) begin
                  r = sgn ? mask : '0;
               end else begin
                  r = (d >> cnt) | (sgn ? (mask & ~(mask >> cnt)) : '0);
               end
               cf = (cnt_m1 < bits) ? sru_pkg::bit_at(d, cnt_m1) : sgn;
               if (cnt_one) of = 1'b0;
               arith = 1'b1;
            end
            sru_pkg::OP_ROL: begin
               if (rot_n != 7'd0) begin
                  r = ((d << rot_n) | (d >> (bits - rot_n))) & mask;
               end
               cf = r[0];
               if (cnt_one) of = r[msb] ^ cf;
            end
            sru_pkg::OP_ROR: begin
               if (rot_n != 7'd0) begin
                  r = ((d >> rot_n) | (d << (bits - rot_n))) & mask;
               end
               cf = r[msb];
               if (cnt_one) of = cf ^ r[msb - 6'd1];
            end
            sru_pkg::OP_SHLD: begin
               if (cnt > bits) begin
                  r  = '0;
                  cf = 1'b0;
               end else begin
                  r  = ((d << cnt) | (f >> bits_m_cnt)) & mask;
                  cf = sru_pkg::bit_at(d, bits_m_cnt);
               end
               if (cnt_one) of = r[msb] ^ cf;
               arith = 1'b1;
            end
            sru_pkg::OP_SHRD: begin
               if (cnt > bits) begin
                  r  = '0;
                  cf = 1'b0;
               end else begin
                  r  = ((d >> cnt) | (f << bits_m_cnt)) & mask;
                  cf = sru_pkg::bit_at(d, cnt_m1);
               end
               if (cnt_one) of = d[msb] ^ r[msb];
               arith = 1'b1;
            end
            sru_pkg::OP_RCL: begin
               if (rc_n != 7'd0) begin
                  r  = ((d << rc_n) | ({63'd0, carry_in} << (rc_n - 7'd1))
                        | (d >> (bits + 7'd1 - rc_n))) & mask;
                  cf = sru_pkg::bit_at(d, bits - rc_n);
               end
               if (cnt_one) of = r[msb] ^ cf;
            end
            sru_pkg::OP_RCR: begin
               if (rc_n != 7'd0) begin
                  r  = ((d >> rc_n) | ({63'd0, carry_in} << (bits - rc_n))
                        | (d << (bits + 7'd1 - rc_n))) & mask;
                  cf = sru_pkg::bit_at(d, rc_n - 7'd1);
               end
               if (cnt_one) of = r[msb] ^ r[msb - 6'd1];
            end
            default: begin
               r = d;
            end
         endcase
      end
   end

   assign shift_out.result   = r;
   assign shift_out.carry    = cf;
   assign shift_out.overflow = of;
   assign shift_out.active   = active;
   assign shift_out.arith    = arith;
   assign shift_out.msb      = msb;

endmodule

// File: src/sru_flags.sv
// zero, sign and parity flags from the shifted result
module sru_flags (
   input  sru_pkg::shift_out_type  shift_out,
   input  logic                    zero_in,
   input  logic                    sign_in,
   input  logic                    parity_in,
   output logic                    zero_out,
   output logic                    sign_out,
   output logic                    parity_out
);

   logic update;

   // rotates and zero counts leave these flags alone
   assign update = shift_out.active && shift_out.arith;

   assign zero_out   = update ? (shift_out.result == '0) : zero_in;
   assign sign_out   = update ? shift_out.result[shift_out.msb] : sign_in;
   assign parity_out = update ? ~^shift_out.result[7:0] : parity_in;

endmodule

// File: src/x86_shift_rotate_unit.sv
// top level of the x86 shift and rotate unit with flag update
//
//   channel   ports             beat taken when
//   request   start, req_*      start high and busy low at a rising edge
//   response  rsp_valid, rsp_*  rsp_valid high for one cycle, always taken
//
// the path from request to response runs through the input register, then the barrel
// shifter and flag logic, then the response register
// one request per cycle, busy stays low, so requests run back to back
// the response receiver cannot stall, so nothing ever holds the pipeline
// synchronous active-high reset clears the two valid bits only
`include "x86_shift_rotate_unit_macros.svh"

module x86_shift_rotate_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [3:0]         req_operation,
   input  logic [1:0]         req_operand_size,
   input  logic [63:0]        req_dest_value,
   input  logic [63:0]        req_fill_value,
   input  logic [7:0]         req_shift_count,
   input  logic               req_carry_in,
   input  logic               req_overflow_in,
   input  logic               req_zero_in,
   input  logic               req_sign_in,
   input  logic               req_parity_in,
   output logic               rsp_valid,
   output logic [63:0]        rsp_result_value,
   output logic               rsp_carry_out,
   output logic               rsp_overflow_out,
   output logic               rsp_zero_out,
   output logic               rsp_sign_out,
   output logic               rsp_parity_out
);

   // input stage
   logic                      st_valid_ff;
   logic                      st_valid_in;
   logic [3:0]                st_op_ff;
   logic [1:0]                st_size_ff;
   sru_pkg::word_type         st_dest_ff;
   sru_pkg::word_type         st_fill_ff;
   logic [7:0]                st_count_ff;
   logic                      st_cf_ff;
   logic                      st_of_ff;
   logic                      st_zf_ff;
   logic                      st_sf_ff;
   logic                      st_pf_ff;

   // response stage
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   sru_pkg::word_type         rsp_result_ff;
   logic                      rsp_cf_ff;
   logic                      rsp_of_ff;
   logic                      rsp_zf_ff;
   logic                      rsp_sf_ff;
   logic                      rsp_pf_ff;

   sru_pkg::shift_out_type    sh_out;
   logic                      zf_next;
   logic                      sf_next;
   logic                      pf_next;
   logic                      accept;

   // the pipeline never backs up, a request can enter every cycle
   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign st_valid_in  = accept;
   assign rsp_valid_in = st_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_valid_ff  <= st_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // request beat capture, payload needs no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         st_op_ff    <= req_operation;
         st_size_ff  <= req_operand_size;
         st_dest_ff  <= req_dest_value;
         st_fill_ff  <= req_fill_value;
         st_count_ff <= req_shift_count;
         st_cf_ff    <= req_carry_in;
         st_of_ff    <= req_overflow_in;
         st_zf_ff    <= req_zero_in;
         st_sf_ff    <= req_sign_in;
         st_pf_ff    <= req_parity_in;
      end
   end

   // barrel shifter with carry and overflow
   sru_shifter u_shifter (
      .operation    (st_op_ff),
      .operand_size (st_size_ff),
      .dest_value   (st_dest_ff),
      .fill_value   (st_fill_ff),
      .shift_count  (st_count_ff),
      .carry_in     (st_cf_ff),
      .overflow_in  (st_of_ff),
      .shift_out    (sh_out)
   );

   // result-derived flags
   sru_flags u_flags (
      .shift_out  (sh_out),
      .zero_in    (st_zf_ff),
      .sign_in    (st_sf_ff),
      .parity_in  (st_pf_ff),
      .zero_out   (zf_next),
      .sign_out   (sf_next),
      .parity_out (pf_next)
   );

   // response beat register
   always_ff @(posedge clock) begin
      if (st_valid_ff) begin
         rsp_result_ff <= sh_out.result;
         rsp_cf_ff     <= sh_out.carry;
         rsp_of_ff     <= sh_out.overflow;
         rsp_zf_ff     <= zf_next;
         rsp_sf_ff     <= sf_next;
         rsp_pf_ff     <= pf_next;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_result_ff;
   assign rsp_carry_out    = rsp_cf_ff;
   assign rsp_overflow_out = rsp_of_ff;
   assign rsp_zero_out     = rsp_zf_ff;
   assign rsp_sign_out     = rsp_sf_ff;
   assign rsp_parity_out   = rsp_pf_ff;

   // every request beat yields a response through the input and response registers
   `SRU_ASSERT_SAME(a_req_to_rsp, clock, reset, accept, ##2 rsp_valid)
   // no response without a beat in the input stage
   `SRU_ASSERT_NEXT(a_no_spurious_rsp, clock, reset, !st_valid_ff, !rsp_valid)
   // shifts that update flags report zero exactly for a zero result
   `SRU_ASSERT_NEXT(a_zero_flag, clock, reset, st_valid_ff && sh_out.active && sh_out.arith,
      rsp_zero_out == (rsp_result_value == 64'd0))
   // byte operands leave the upper result bits clear
   `SRU_ASSERT_NEXT(a_byte_upper_clear, clock, reset,
      st_valid_ff && (st_size_ff == sru_pkg::SIZE_BYTE), rsp_result_value[63:8] == 56'd0)

endmodule

// File: tb/x86_shift_rotate_unit_tb.sv
// self-checking testbench of the x86 shift and rotate unit with flag update
`timescale 1ns / 1ps

module x86_shift_rotate_unit_tb;

   // one command beat as it goes onto the req_ ports
   typedef struct {
      logic [3:0]  operation;
      logic [1:0]  size;
      logic [63:0] dest;
      logic [63:0] fill;
      logic [7:0]  count;
      logic        carry;
      logic        overflow;
      logic        zero;
      logic        sign;
      logic        parity;
   } shift_command_type;

   // one result beat as it comes off the rsp_ ports
   typedef struct {
      logic [63:0] value;
      logic        carry;
      logic        overflow;
      logic        zero;
      logic        sign;
      logic        parity;
   } shift_result_type;

   // operation codes above OP_RCR are undefined, the block must pass them through
   localparam logic [3:0] OP_UNDEFINED_LAST = 4'hF;
   localparam int unsigned CYCLE_LIMIT = 50000;
   // two-stage pipeline, then spare cycles to catch stray beats
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam int unsigned RANDOM_COMMANDS = 950;

   // predicts shift results and flags and holds them until the block answers
   class shift_flag_scoreboard;
      shift_result_type pending_results[$];
      int unsigned      mismatches;

      function new();
         mismatches = 0;
      endfunction

      function logic [63:0] lsl(logic [63:0] x, int n);
         return (n < 0 || n >= 64) ? 64'd0 : x << n;
      endfunction

      function logic [63:0] lsr(logic [63:0] x, int n);
         return (n < 0 || n >= 64) ? 64'd0 : x >> n;
      endfunction

      function logic bit_of(logic [63:0] x, int n);
         return (n < 0 || n >= 64) ? 1'b0 : x[n];
      endfunction

      function shift_result_type shift_and_flags(shift_command_type c);
         shift_result_type o;
         int            width, cnt, top, n;
         logic [63:0]   mask, d, f, r;
         logic          cf, of, zf, sf, pf, sgn, ncf, arith;
         width = 8 << c.size;
         mask  = (width == 64) ? '1 : (64'd1 << width) - 64'd1;
         d     = c.dest & mask;
         f     = c.fill & mask;
         cnt   = int'(c.count[5:0] & ((width == 64) ? sru_pkg::CNT_MASK_WIDE
                                                   : sru_pkg::CNT_MASK_NARROW));
         top   = width - 1;
         cf    = c.carry;
         of    = c.overflow;
         zf    = c.zero;
         sf    = c.sign;
         pf    = c.parity;
         r     = d;
         arith = 1'b0;
         // a masked count of zero and undefined codes leave everything alone
         if (cnt != 0 && c.operation <= sru_pkg::OP_RCR) begin
            case (c.operation)
               sru_pkg::OP_SHL: begin
                  r  = lsl(d, cnt) & mask;
                  cf = (cnt <= width) ? bit_of(d, width - cnt) : 1'b0;
                  if (cnt == 1) of = bit_of(r, top) ^ cf;
                  arith = 1'b1;
               end
               sru_pkg::OP_SHR: begin
                  r  = lsr(d, cnt);
                  cf = bit_of(d, cnt - 1);
                  if (cnt == 1) of = bit_of(d, top);
                  arith = 1'b1;
               end
               sru_pkg::OP_SAR: begin
                  sgn = bit_of(d, top);
                  if (cnt >= width) begin
                     r = sgn ? mask : 64'd0;
                  end else begin
                     r = lsr(d, cnt);
                     if (sgn) r = r | (mask & ~lsr(mask, cnt));
                  end
                  cf = (cnt - 1 < width) ? bit_of(d, cnt - 1) : sgn;
                  if (cnt == 1) of = 1'b0;
                  arith = 1'b1;
               end
               sru_pkg::OP_ROL: begin
                  n  = cnt & top;
                  r  = (n != 0) ? ((lsl(d, n) | lsr(d, width - n)) & mask) : d;
                  cf = bit_of(r, 0);
                  if (cnt == 1) of = bit_of(r, top) ^ cf;
               end
               sru_pkg::OP_ROR: begin
                  n  = cnt & top;
                  r  = (n != 0) ? ((lsr(d, n) | lsl(d, width - n)) & mask) : d;
                  cf = bit_of(r, top);
                  if (cnt == 1) of = cf ^ bit_of(r, top - 1);
               end
               sru_pkg::OP_SHLD: begin
                  if (cnt > width) begin
                     r  = 64'd0;
                     cf = 1'b0;
                  end else begin
                     r  = (lsl(d, cnt) | lsr(f, width - cnt)) & mask;
                     cf = bit_of(d, width - cnt);
                  end
                  if (cnt == 1) of = bit_of(r, top) ^ cf;
                  arith = 1'b1;
               end
               sru_pkg::OP_SHRD: begin
                  if (cnt > width) begin
                     r  = 64'd0;
                     cf = 1'b0;
                  end else begin
                     r  = (lsr(d, cnt) | lsl(f, width - cnt)) & mask;
                     cf = bit_of(d, cnt - 1);
                  end
                  if (cnt == 1) of = bit_of(d, top) ^ bit_of(r, top);
                  arith = 1'b1;
               end
               sru_pkg::OP_RCL: begin
                  n = (width < 32) ? cnt % (width + 1) : cnt;
                  if (n != 0) begin
                     ncf = bit_of(d, width - n);
                     r   = (lsl(d, n) | lsl({63'd0, cf}, n - 1) | lsr(d, width + 1 - n)) & mask;
                     cf  = ncf;
                  end
                  if (cnt == 1) of = bit_of(r, top) ^ cf;
               end
               default: begin
                  n = (width < 32) ? cnt % (width + 1) : cnt;
                  if (n != 0) begin
                     ncf = bit_of(d, n - 1);
                     r   = (lsr(d, n) | lsl({63'd0, cf}, width - n)
                           | lsl(d, width + 1 - n)) & mask;
                     cf  = ncf;
                  end
                  if (cnt == 1) of = bit_of(r, top) ^ bit_of(r, top - 1);
               end
            endcase
            if (arith) begin
               zf = (r == 64'd0);
               sf = bit_of(r, top);
               pf = ~^r[7:0];
            end
         end
         o.value    = r & mask;
         o.carry    = cf;
         o.overflow = of;
         o.zero     = zf;
         o.sign     = sf;
         o.parity   = pf;
         return o;
      endfunction

      function void note_command(shift_command_type c);
         pending_results.push_back(shift_and_flags(c));
      endfunction

      function void check_result(shift_result_type got);
         shift_result_type want;
         if (pending_results.size() == 0) begin
            $display("%0t: result beat with none expected, value %h", $time, got.value);
            mismatches++;
            return;
         end
         want = pending_results.pop_front();
         if (got.value !== want.value) begin
            $display("%0t: result_value expected %h actual %h", $time, want.value, got.value);
            mismatches++;
         end
         if (got.carry !== want.carry) begin
            $display("%0t: carry_out expected %b actual %b", $time, want.carry, got.carry);
            mismatches++;
         end
         if (got.overflow !== want.overflow) begin
            $display("%0t: overflow_out expected %b actual %b", $time, want.overflow,
                     got.overflow);
            mismatches++;
         end
         if (got.zero !== want.zero) begin
            $display("%0t: zero_out expected %b actual %b", $time, want.zero, got.zero);
            mismatches++;
         end
         if (got.sign !== want.sign) begin
            $display("%0t: sign_out expected %b actual %b", $time, want.sign, got.sign);
            mismatches++;
         end
         if (got.parity !== want.parity) begin
            $display("%0t: parity_out expected %b actual %b", $time, want.parity, got.parity);
            mismatches++;
         end
      endfunction

      function int pending();
         return pending_results.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [3:0]  req_operation;
   logic [1:0]  req_operand_size;
   logic [63:0] req_dest_value;
   logic [63:0] req_fill_value;
   logic [7:0]  req_shift_count;
   logic        req_carry_in;
   logic        req_overflow_in;
   logic        req_zero_in;
   logic        req_sign_in;
   logic        req_parity_in;
   logic        rsp_valid;
   logic [63:0] rsp_result_value;
   logic        rsp_carry_out;
   logic        rsp_overflow_out;
   logic        rsp_zero_out;
   logic        rsp_sign_out;
   logic        rsp_parity_out;

   shift_flag_scoreboard sb = new();
   // cleared during the long back-to-back stretch of the random part
   bit           gaps_enabled;
   int unsigned  cycle_count;

   x86_shift_rotate_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_operation    (req_operation),
      .req_operand_size (req_operand_size),
      .req_dest_value   (req_dest_value),
      .req_fill_value   (req_fill_value),
      .req_shift_count  (req_shift_count),
      .req_carry_in     (req_carry_in),
      .req_overflow_in  (req_overflow_in),
      .req_zero_in      (req_zero_in),
      .req_sign_in      (req_sign_in),
      .req_parity_in    (req_parity_in),
      .rsp_valid        (rsp_valid),
      .rsp_result_value (rsp_result_value),
      .rsp_carry_out    (rsp_carry_out),
      .rsp_overflow_out (rsp_overflow_out),
      .rsp_zero_out     (rsp_zero_out),
      .rsp_sign_out     (rsp_sign_out),
      .rsp_parity_out   (rsp_parity_out)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // monitor: at each rising edge check the result beat that ends here, then
   // note the command beat taken at the same edge; the pipeline is two deep so
   // a command never answers at its own edge
   always @(posedge clock) begin
      shift_command_type c;
      shift_result_type  got;
      if (!reset) begin
         if (rsp_valid) begin
            got.value    = rsp_result_value;
            got.carry    = rsp_carry_out;
            got.overflow = rsp_overflow_out;
            got.zero     = rsp_zero_out;
            got.sign     = rsp_sign_out;
            got.parity   = rsp_parity_out;
            sb.check_result(got);
         end
         if (start && !busy) begin
            c.operation = req_operation;
            c.size      = req_operand_size;
            c.dest      = req_dest_value;
            c.fill      = req_fill_value;
            c.count     = req_shift_count;
            c.carry     = req_carry_in;
            c.overflow  = req_overflow_in;
            c.zero      = req_zero_in;
            c.sign      = req_sign_in;
            c.parity    = req_parity_in;
            sb.note_command(c);
         end
      end
   end

   // command with the given fields and random incoming flags
   function automatic shift_command_type make_command(logic [3:0] op, logic [1:0] size,
                                                      logic [63:0] dest, logic [63:0] fill,
                                                      logic [7:0] count);
      shift_command_type c;
      c.operation = op;
      c.size      = size;
      c.dest      = dest;
      c.fill      = fill;
      c.count     = count;
      c.carry     = 1'($urandom);
      c.overflow  = 1'($urandom);
      c.zero      = 1'($urandom);
      c.sign      = 1'($urandom);
      c.parity    = 1'($urandom);
      return c;
   endfunction

   // random command biased toward the count and value corners of each size
   function automatic shift_command_type random_command();
      logic [3:0]  op;
      logic [1:0]  size;
      logic [63:0] dest;
      logic [7:0]  count;
      int          width;
      op    = ($urandom_range(99) < 6) ? 4'($urandom_range(15, 9)) : 4'($urandom_range(8));
      size  = 2'($urandom);
      width = 8 << size;
      case ($urandom_range(9))
         0:       dest = 64'd0;
         1:       dest = '1;
         2:       dest = 64'd1 << $urandom_range(63);
         3:       dest = ~(64'd1 << $urandom_range(63));
         // sign bit of the operand set, the rest random
         4:       dest = {$urandom, $urandom} | (64'd1 << (width - 1));
         default: dest = {$urandom, $urandom};
      endcase
      case ($urandom_range(9))
         0, 1:    count = 8'd1;
         2, 3:    count = 8'($urandom_range(7));
         // around the operand width: last in-range, exact and over-wide
         4, 5:    count = 8'(width - 1 + $urandom_range(2));
         // multiples of the width, where byte and word rotates wrap around
         6:       count = 8'(width * $urandom_range(3));
         7:       count = 8'($urandom_range(31));
         default: count = 8'($urandom);
      endcase
      // junk above the count mask must be ignored
      if ($urandom_range(99) < 30) begin
         if (size == sru_pkg::SIZE_QWORD) count = count | 8'($urandom_range(3) << 6);
         else                             count = count | 8'($urandom_range(7) << 5);
      end
      return make_command(op, size, dest, {$urandom, $urandom}, count);
   endfunction

   // drive one command beat, entered and left just after a falling edge
   task automatic send_command(input shift_command_type c);
      while (gaps_enabled && $urandom_range(99) < 21) begin
         start = 1'b0;
         @(negedge clock);
      end
      req_operation    = c.operation;
      req_operand_size = c.size;
      req_dest_value   = c.dest;
      req_fill_value   = c.fill;
      req_shift_count  = c.count;
      req_carry_in     = c.carry;
      req_overflow_in  = c.overflow;
      req_zero_in      = c.zero;
      req_sign_in      = c.sign;
      req_parity_in    = c.parity;
      start            = 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   // watchdog, far above the slowest correct run
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("x86_shift_rotate_unit regression: fail");
      $finish;
   end

   initial begin
      reset            = 1'b1;
      start            = 1'b0;
      req_operation    = '0;
      req_operand_size = '0;
      req_dest_value   = '0;
      req_fill_value   = '0;
      req_shift_count  = '0;
      req_carry_in     = 1'b0;
      req_overflow_in  = 1'b0;
      req_zero_in      = 1'b0;
      req_sign_in      = 1'b0;
      req_parity_in    = 1'b0;
      gaps_enabled     = 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed corners: every operation, count of one, width edges
      send_command(make_command(sru_pkg::OP_SHL, sru_pkg::SIZE_BYTE, 64'h81, '1, 8'd1));
      send_command(make_command(sru_pkg::OP_SHL, sru_pkg::SIZE_QWORD, '1, 64'd0, 8'd63));
      send_command(make_command(sru_pkg::OP_SHR, sru_pkg::SIZE_WORD, 64'h8001, '1, 8'd1));
      // count equal to the width, then over-wide
      send_command(make_command(sru_pkg::OP_SHR, sru_pkg::SIZE_BYTE, 64'hFF, 64'd0, 8'd8));
      send_command(make_command(sru_pkg::OP_SHL, sru_pkg::SIZE_BYTE, 64'hFF, 64'd0, 8'd20));
      send_command(make_command(sru_pkg::OP_SAR, sru_pkg::SIZE_BYTE, 64'h80, 64'd0, 8'd31));
      send_command(make_command(sru_pkg::OP_SAR, sru_pkg::SIZE_DWORD, 64'h8000_0001,
                                64'd0, 8'd1));
      send_command(make_command(sru_pkg::OP_SAR, sru_pkg::SIZE_QWORD,
                                64'h8000_0000_0000_0000, '1, 8'd63));
      // byte and word rotate by a multiple of the width still updates carry
      send_command(make_command(sru_pkg::OP_ROL, sru_pkg::SIZE_BYTE, 64'h81, 64'd0, 8'd8));
      send_command(make_command(sru_pkg::OP_ROR, sru_pkg::SIZE_WORD, 64'h8001, 64'd0, 8'd16));
      send_command(make_command(sru_pkg::OP_ROL, sru_pkg::SIZE_QWORD,
                                64'h8000_0000_0000_0001, 64'd0, 8'd1));
      send_command(make_command(sru_pkg::OP_ROR, sru_pkg::SIZE_DWORD, 64'h0000_0001,
                                64'd0, 8'd1));
      // over-wide double shifts on words
      send_command(make_command(sru_pkg::OP_SHLD, sru_pkg::SIZE_WORD, 64'hFFFF, '1, 8'd20));
      send_command(make_command(sru_pkg::OP_SHRD, sru_pkg::SIZE_WORD, 64'hFFFF, '1, 8'd31));
      send_command(make_command(sru_pkg::OP_SHLD, sru_pkg::SIZE_QWORD,
                                64'h4000_0000_0000_0000, '1, 8'd1));
      send_command(make_command(sru_pkg::OP_SHRD, sru_pkg::SIZE_DWORD, 64'h1234_5678,
                                64'h9ABC_DEF0, 8'd16));
      // rotate through carry with an amount that wraps to zero
      send_command(make_command(sru_pkg::OP_RCL, sru_pkg::SIZE_BYTE, 64'hA5, 64'd0, 8'd9));
      send_command(make_command(sru_pkg::OP_RCR, sru_pkg::SIZE_WORD, 64'h5A5A, 64'd0, 8'd17));
      send_command(make_command(sru_pkg::OP_RCL, sru_pkg::SIZE_QWORD,
                                64'h8000_0000_0000_0000, 64'd0, 8'd1));
      send_command(make_command(sru_pkg::OP_RCR, sru_pkg::SIZE_BYTE, 64'h01, 64'd0, 8'd8));
      send_command(make_command(sru_pkg::OP_RCR, sru_pkg::SIZE_DWORD, '1, 64'd0, 8'd31));
      // undefined code passes the masked destination and all flags
      send_command(make_command(OP_UNDEFINED_LAST, sru_pkg::SIZE_QWORD, '1, '1, 8'd5));
      // counts that mask to zero leave the flags alone; then a masked count of 63 and a zero word operand
      send_command(make_command(sru_pkg::OP_SHL, sru_pkg::SIZE_DWORD, '1, '1, 8'd32));
      send_command(make_command(sru_pkg::OP_SHR, sru_pkg::SIZE_QWORD, '1, '1, 8'hC0));
      send_command(make_command(sru_pkg::OP_SHR, sru_pkg::SIZE_QWORD, '1, 64'd0, 8'hFF));
      send_command(make_command(sru_pkg::OP_SHL, sru_pkg::SIZE_WORD, 64'd0, '1, 8'd3));

      // random part with a long back-to-back stretch in the middle
      for (int i = 0; i < RANDOM_COMMANDS; i++) begin
         gaps_enabled = !(i >= 350 && i < 600);
         send_command(random_command());
      end
      start = 1'b0;

      // drain the pipeline, then leave room for any stray result beat
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.mismatches == 0) begin
         $display("x86_shift_rotate_unit regression: pass");
      end else begin
         $display("x86_shift_rotate_unit regression: fail");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+src
src/sru_pkg.sv
src/sru_shifter.sv
src/sru_flags.sv
src/x86_shift_rotate_unit.sv
tb/x86_shift_rotate_unit_tb.sv
